// ===== rtl/gse_pkg.sv =====
// Package for the bilinear grid surface evaluator.
// Holds the item and result structs, the configuration register indexes and the mode codes.
`timescale 1ns / 1ps

package gse_pkg;

  localparam int COORD_W   = 32;
  localparam int SPAN_W    = 31;
  localparam int GRID_W    = 7;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_U_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_U_SPAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_V_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V_SPAN    = 3'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [IDX_W-1:0]           col_index;
    logic [IDX_W-1:0]           row_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic signed [COORD_W-1:0]  u_param;
    logic signed [COORD_W-1:0]  v_param;
  } gse_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  surf_x;
    logic signed [COORD_W-1:0]  surf_y;
    logic signed [COORD_W-1:0]  surf_z;
  } gse_out_t;

endpackage

// ===== rtl/gse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gse_norm.sv =====
// Parameter normalizer: maps a parameter into [0, ONE] against low and span.
// Pipelined restoring divider, one quotient bit per stage; uses gse_pkg.
`timescale 1ns / 1ps

module gse_norm import gse_pkg::*; #(
  parameter int FB = 16
) (
  input  logic                      clk_i,
  input  logic signed [COORD_W-1:0] param_i,
  input  logic signed [COORD_W-1:0] low_i,
  input  logic [SPAN_W-1:0]         span_i,
  output logic [FB:0]               t_o
);

  logic signed [COORD_W:0] diff;
  logic                    zero_d;
  logic                    one_d;

  logic [SPAN_W-1:0] rem_q  [FB];
  logic [FB-1:0]     quo_q  [1:FB];
  logic              zero_q [FB+1];
  logic              one_q  [FB+1];

  assign diff   = {param_i[COORD_W-1], param_i} - {low_i[COORD_W-1], low_i};
  assign zero_d = (span_i == '0) || diff[COORD_W] || (diff == '0);
  assign one_d  = !zero_d && ($unsigned(diff) >= {2'b00, span_i});

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= diff[SPAN_W-1:0];
    zero_q[0] <= zero_d;
    one_q[0]  <= one_d;
  end

  for (genvar k = 1; k <= FB; k++) begin : g_stage
    logic [SPAN_W:0] r2;
    logic            ge;

    assign r2 = {rem_q[k-1], 1'b0};
    assign ge = r2 >= {1'b0, span_i};

    always_ff @(posedge clk_i) begin
      zero_q[k] <= zero_q[k-1];
      one_q[k]  <= one_q[k-1];
    end

    if (k < FB) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? SPAN_W'(r2 - {1'b0, span_i}) : r2[SPAN_W-1:0];
      end
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk_i) begin
        quo_q[k] <= FB'(ge);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        quo_q[k] <= {quo_q[k-1][FB-2:0], ge};
      end
    end
  end

  always_comb begin
    if (one_q[FB]) begin
      t_o = {1'b1, {FB{1'b0}}};
    end else if (zero_q[FB]) begin
      t_o = '0;
    end else begin
      t_o = {1'b0, quo_q[FB]};
    end
  end

endmodule

// ===== rtl/gse_lerp.sv =====
// Two-stage linear blend p0 + round((p1 - p0) * w), rounding to nearest, ties up.
// Uses gse_pkg for the coordinate width.
`timescale 1ns / 1ps

module gse_lerp import gse_pkg::*; #(
  parameter int FB = 16
) (
  input  logic                      clk_i,
  input  logic signed [COORD_W-1:0] p0_i,
  input  logic signed [COORD_W-1:0] p1_i,
  input  logic [FB-1:0]             w_i,
  output logic signed [COORD_W-1:0] p_o
);

  localparam int PW = COORD_W + FB + 2;

  logic signed [COORD_W:0]   d;
  logic signed [PW-1:0]      prod_d;
  logic signed [PW-1:0]      prod_q;
  logic signed [COORD_W-1:0] p0_q;
  logic signed [PW-1:0]      sum;
  logic signed [PW-1:0]      shifted;
  logic signed [COORD_W-1:0] p_q;

  assign d      = {p1_i[COORD_W-1], p1_i} - {p0_i[COORD_W-1], p0_i};
  assign prod_d = d * $signed({1'b0, w_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    p0_q   <= p0_i;
  end

  assign sum     = prod_q + $signed(PW'(1) <<< (FB - 1));
  assign shifted = sum >>> FB;

  always_ff @(posedge clk_i) begin
    p_q <= p0_q + shifted[COORD_W-1:0];
  end

  assign p_o = p_q;

endmodule

// ===== rtl/bilinear_grid_surface_eval.sv =====
// Bilinear surface evaluator over a grid of 3D control points in four parity banks.
// Throughput: one item per cycle, writes and evaluations mixed freely; busy stays low.
// An evaluate result strobes after the one-bit-per-stage normalizing divider, the scale
// register, the bank read register, the two blend passes and the output register.
// Reset clears configuration to its defaults and the pipeline valids; the point
// store is not cleared. The receiver cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps

module bilinear_grid_surface_eval import gse_pkg::*; #(
  parameter int MAX_COLS        = 64,
  parameter int MAX_ROWS        = 64,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  gse_in_t              item_i,
  output logic                 result_strobe_o,
  output gse_out_t             result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int FB     = COORD_FRAC_BITS;
  localparam int CW_C   = $clog2(MAX_COLS + 1);
  localparam int CW_R   = $clog2(MAX_ROWS + 1);
  localparam int CW_M   = (CW_C > CW_R) ? CW_C : CW_R;
  localparam int CNT_W  = (CW_M > GRID_W) ? CW_M : GRID_W;
  localparam int HC     = (MAX_COLS + 1) / 2;
  localparam int HR     = (MAX_ROWS + 1) / 2;
  localparam int BDEPTH = (HC * HR < 2) ? 2 : HC * HR;
  localparam int BAW    = $clog2(BDEPTH);
  localparam int FUW    = FB + 1 + CNT_W;
  localparam int PT_W   = 3 * COORD_W;
  localparam int EV_LAT = 5;

  typedef struct packed {
    logic               mode;
    logic               wr_ok;
    logic [CNT_W-1:0]   col;
    logic [CNT_W-1:0]   row;
    logic [PT_W-1:0]    pt;
  } pipe_t;

  // configuration registers
  logic [GRID_W-1:0]  grid_cols_q, grid_rows_q;
  logic [COORD_W-1:0] u_low_q, v_low_q;
  logic [SPAN_W-1:0]  u_span_q, v_span_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GRID_W'(2);
      grid_rows_q <= GRID_W'(2);
      u_low_q     <= '0;
      u_span_q    <= SPAN_W'(65536);
      v_low_q     <= '0;
      v_span_q    <= SPAN_W'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[GRID_W-1:0];
        CFG_U_LOW:     u_low_q     <= cfg_data_i;
        CFG_U_SPAN:    u_span_q    <= cfg_data_i[SPAN_W-1:0];
        CFG_V_LOW:     v_low_q     <= cfg_data_i;
        CFG_V_SPAN:    v_span_q    <= cfg_data_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated grid size
  logic [CNT_W-1:0] nc, nr, mul_u, mul_v;
  logic             small_grid;

  always_comb begin
    nc = (CNT_W'(grid_cols_q) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(grid_cols_q);
    nr = (CNT_W'(grid_rows_q) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(grid_rows_q);
    small_grid = (nc < CNT_W'(2)) || (nr < CNT_W'(2));
    mul_u = small_grid ? '0 : nc - CNT_W'(1);
    mul_v = small_grid ? '0 : nr - CNT_W'(1);
  end

  // normalizers
  logic [FB:0] t_u, t_v;

  gse_norm #(.FB(FB)) u_norm_u (
    .clk_i   (clk_i),
    .param_i (item_i.u_param),
    .low_i   (u_low_q),
    .span_i  (u_span_q),
    .t_o     (t_u)
  );

  gse_norm #(.FB(FB)) u_norm_v (
    .clk_i   (clk_i),
    .param_i (item_i.v_param),
    .low_i   (v_low_q),
    .span_i  (v_span_q),
    .t_o     (t_v)
  );

  // payload delay line, aligned with the divider output
  pipe_t dl_q  [FB+1];
  logic  dlv_q [FB+1];
  pipe_t in_p;

  always_comb begin
    in_p.mode  = item_i.mode;
    in_p.col   = CNT_W'(item_i.col_index);
    in_p.row   = CNT_W'(item_i.row_index);
    in_p.wr_ok = (CNT_W'(item_i.col_index) < CNT_W'(MAX_COLS)) &&
                 (CNT_W'(item_i.row_index) < CNT_W'(MAX_ROWS));
    in_p.pt    = {item_i.point_x, item_i.point_y, item_i.point_z};
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= in_p;
    for (int k = 1; k <= FB; k++) begin
      dl_q[k] <= dl_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= FB; k++) begin
        dlv_q[k] <= 1'b0;
      end
    end else begin
      dlv_q[0] <= start;
      for (int k = 1; k <= FB; k++) begin
        dlv_q[k] <= dlv_q[k-1];
      end
    end
  end

  // scale stage
  logic [FUW-1:0] fu_q, fv_q;
  pipe_t          is_q;
  logic           is_vld_q;

  always_ff @(posedge clk_i) begin
    fu_q <= FUW'(t_u) * FUW'(mul_u);
    fv_q <= FUW'(t_v) * FUW'(mul_v);
    is_q <= dl_q[FB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_vld_q <= 1'b0;
    end else begin
      is_vld_q <= dlv_q[FB];
    end
  end

  // memory issue: reads and writes in item order at one stage
  logic [CNT_W-1:0] i0, i1, j0, j1;
  logic [FB-1:0]    wa, wb;

  always_comb begin
    i0 = fu_q[FB +: CNT_W];
    j0 = fv_q[FB +: CNT_W];
    wa = fu_q[FB-1:0];
    wb = fv_q[FB-1:0];
    i1 = (CNT_W'(i0 + CNT_W'(1)) < nc) ? CNT_W'(i0 + CNT_W'(1)) : i0;
    j1 = (CNT_W'(j0 + CNT_W'(1)) < nr) ? CNT_W'(j0 + CNT_W'(1)) : j0;
  end

  logic [PT_W-1:0] bank_rd [4];
  logic [BAW-1:0]  wr_addr;
  logic            wr_en;

  assign wr_en   = is_vld_q && (is_q.mode == MODE_WRITE) && is_q.wr_ok;
  assign wr_addr = BAW'(int'(is_q.row >> 1) * HC + int'(is_q.col >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CNT_W-1:0] col_b, row_b;
    logic [BAW-1:0]   rd_addr;
    logic             we_b;

    assign col_b   = (i0[0] == b[0]) ? i0 : i1;
    assign row_b   = (j0[0] == b[1]) ? j0 : j1;
    assign rd_addr = BAW'(int'(row_b >> 1) * HC + int'(col_b >> 1));
    assign we_b    = wr_en && (is_q.col[0] == b[0]) && (is_q.row[0] == b[1]);

    gse_ram #(.WIDTH(PT_W), .DEPTH(BDEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_b),
      .waddr_i (wr_addr),
      .wdata_i (is_q.pt),
      .raddr_i (rd_addr),
      .rdata_o (bank_rd[b])
    );
  end

  // read-data stage: route banks to corners
  logic          i0p_q, i1p_q, j0p_q, j1p_q;
  logic [FB-1:0] wa_q;
  logic [FB-1:0] wb_q [3];
  logic          ev_q [EV_LAT];

  always_ff @(posedge clk_i) begin
    i0p_q   <= i0[0];
    i1p_q   <= i1[0];
    j0p_q   <= j0[0];
    j1p_q   <= j1[0];
    wa_q    <= wa;
    wb_q[0] <= wb;
    wb_q[1] <= wb_q[0];
    wb_q[2] <= wb_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < EV_LAT; k++) begin
        ev_q[k] <= 1'b0;
      end
    end else begin
      ev_q[0] <= is_vld_q && (is_q.mode == MODE_EVAL);
      for (int k = 1; k < EV_LAT; k++) begin
        ev_q[k] <= ev_q[k-1];
      end
    end
  end

  logic [2:0][COORD_W-1:0] p00, p10, p01, p11;

  assign p00 = bank_rd[{j0p_q, i0p_q}];
  assign p10 = bank_rd[{j0p_q, i1p_q}];
  assign p01 = bank_rd[{j1p_q, i0p_q}];
  assign p11 = bank_rd[{j1p_q, i1p_q}];

  logic signed [COORD_W-1:0] v0 [3];
  logic signed [COORD_W-1:0] v1 [3];
  logic signed [COORD_W-1:0] vr [3];

  for (genvar k = 0; k < 3; k++) begin : g_coord
    gse_lerp #(.FB(FB)) u_lerp_r0 (
      .clk_i (clk_i),
      .p0_i  ($signed(p00[k])),
      .p1_i  ($signed(p10[k])),
      .w_i   (wa_q),
      .p_o   (v0[k])
    );

    gse_lerp #(.FB(FB)) u_lerp_r1 (
      .clk_i (clk_i),
      .p0_i  ($signed(p01[k])),
      .p1_i  ($signed(p11[k])),
      .w_i   (wa_q),
      .p_o   (v1[k])
    );

    gse_lerp #(.FB(FB)) u_lerp_v (
      .clk_i (clk_i),
      .p0_i  (v0[k]),
      .p1_i  (v1[k]),
      .w_i   (wb_q[2]),
      .p_o   (vr[k])
    );
  end

  // output register; force zero for a degenerate grid
  gse_out_t res_q;
  logic     strobe_q;

  always_ff @(posedge clk_i) begin
    if (small_grid) begin
      res_q <= '0;
    end else begin
      res_q.surf_x <= vr[2];
      res_q.surf_y <= vr[1];
      res_q.surf_z <= vr[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ev_q[EV_LAT-1];
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for bilinear_grid_surface_eval: loads control grids, evaluates (u,v) pairs
// and checks every result against a local bilinear predictor. Depends on gse_pkg.
`timescale 1ns / 1ps

module tb_top;
  import gse_pkg::*;

  localparam int MAXC = 64;
  localparam int MAXR = 64;
  localparam int FRAC = 16;
  localparam longint ONE = 64'd1 << FRAC;
  localparam int LATENCY = FRAC + 7;
  localparam int FILL_LO = 16;  // low corner block of the store that gets loaded
  localparam int FILL_N  = FILL_LO + 2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  gse_in_t              item_i;
  logic                 result_strobe_o;
  gse_out_t             result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  bilinear_grid_surface_eval u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_strobe_o(result_strobe_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [6:0]  cols_q, rows_q;
  logic [31:0] ulow_q, vlow_q;
  logic [30:0] uspan_q, vspan_q;
  logic [31:0] grid_x [MAXC*MAXR];
  logic [31:0] grid_y [MAXC*MAXR];
  logic [31:0] grid_z [MAXC*MAXR];

  gse_out_t surf_queue[$];
  int       mismatches;
  bit       calm;  // no idling when set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("bilinear_grid_surface_eval: mismatch");
    $finish;
  end

  function automatic longint norm_param(logic [31:0] p, logic [31:0] lo, logic [30:0] span);
    longint diff;
    diff = longint'($signed(p)) - longint'($signed(lo));
    if (span == 0 || diff <= 0) return 0;
    if (diff >= longint'(span)) return ONE;
    return (diff << FRAC) / longint'(span);
  endfunction

  function automatic longint lerp_round(longint p0, longint p1, longint w);
    longint s;
    s = p0 * (ONE - w) + p1 * w + (ONE >>> 1);
    return s >>> FRAC;
  endfunction

  function automatic longint pick(int c, int r, int k);
    int a;
    a = r * MAXC + c;
    case (k)
      0: return longint'($signed(grid_x[a]));
      1: return longint'($signed(grid_y[a]));
      default: return longint'($signed(grid_z[a]));
    endcase
  endfunction

  function automatic gse_out_t eval_surface(gse_in_t it);
    gse_out_t o;
    int nc, nr, i0, j0, i1, j1;
    longint fu, fv, a, b, v0, v1;
    logic [31:0] res [3];
    nc = (cols_q > MAXC) ? MAXC : cols_q;
    nr = (rows_q > MAXR) ? MAXR : rows_q;
    if (nc < 2 || nr < 2) return '0;
    fu = norm_param(it.u_param, ulow_q, uspan_q) * (nc - 1);
    fv = norm_param(it.v_param, vlow_q, vspan_q) * (nr - 1);
    i0 = int'(fu >> FRAC);
    j0 = int'(fv >> FRAC);
    a = fu & (ONE - 1);
    b = fv & (ONE - 1);
    i1 = (i0 + 1 < nc) ? i0 + 1 : i0;
    j1 = (j0 + 1 < nr) ? j0 + 1 : j0;
    for (int k = 0; k < 3; k++) begin
      v0 = lerp_round(pick(i0, j0, k), pick(i1, j0, k), a);
      v1 = lerp_round(pick(i0, j1, k), pick(i1, j1, k), a);
      res[k] = 32'(lerp_round(v0, v1, b));
    end
    o.surf_x = res[0];
    o.surf_y = res[1];
    o.surf_z = res[2];
    return o;
  endfunction

  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_item(gse_in_t it);
    int a;
    idle_gap();
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.mode == MODE_WRITE) begin
      a = it.row_index * MAXC + it.col_index;
      grid_x[a] = it.point_x;
      grid_y[a] = it.point_y;
      grid_z[a] = it.point_z;
    end else begin
      surf_queue.push_back(eval_surface(it));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (surf_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_GRID_COLS: cols_q  = val[6:0];
      CFG_GRID_ROWS: rows_q  = val[6:0];
      CFG_U_LOW:     ulow_q  = val;
      CFG_U_SPAN:    uspan_q = val[30:0];
      CFG_V_LOW:     vlow_q  = val;
      CFG_V_SPAN:    vspan_q = val[30:0];
      default:       ;
    endcase
  endtask

  task automatic set_grid(int c, int r, logic [31:0] ul, logic [30:0] us,
                          logic [31:0] vl, logic [30:0] vs);
    drain();
    write_reg(CFG_GRID_COLS, 32'(c));
    write_reg(CFG_GRID_ROWS, 32'(r));
    write_reg(CFG_U_LOW, ul);
    write_reg(CFG_U_SPAN, {1'b0, us});
    write_reg(CFG_V_LOW, vl);
    write_reg(CFG_V_SPAN, {1'b0, vs});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic gse_in_t rand_item();
    gse_in_t it;
    it = '0;
    it.mode      = 1'($urandom_range(1));
    it.col_index = 6'($urandom);
    it.row_index = 6'($urandom);
    it.point_x   = $urandom;
    it.point_y   = $urandom;
    it.point_z   = $urandom;
    it.u_param   = $urandom;
    it.v_param   = $urandom;
    return it;
  endfunction

  task automatic load_point(int c, int r, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    gse_in_t it;
    it = rand_item();
    it.mode = MODE_WRITE;
    it.col_index = 6'(c);
    it.row_index = 6'(r);
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    send_item(it);
  endtask

  // load the low corner block and the last two rows and columns; every grid
  // below reads only those entries
  task automatic test_fill_store();
    int c, r;
    calm = 1'b1;
    for (int rr = 0; rr < FILL_N; rr++) begin
      for (int cc = 0; cc < FILL_N; cc++) begin
        r = (rr < FILL_LO) ? rr : rr + (MAXR - FILL_N);
        c = (cc < FILL_LO) ? cc : cc + (MAXC - FILL_N);
        load_point(c, r, $urandom, $urandom, $urandom);
      end
    end
    calm = 1'b0;
  endtask

  task automatic eval_at(logic [31:0] u, logic [31:0] v);
    gse_in_t it;
    it = rand_item();
    it.mode = MODE_EVAL;
    it.u_param = u;
    it.v_param = v;
    send_item(it);
  endtask

  task automatic test_directed();
    // extremes of the coordinates at the corners of a 2x2 grid
    load_point(0, 0, 32'h7fffffff, 32'h80000000, 32'h0);
    load_point(1, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    load_point(0, 1, 32'hffffffff, 32'h1, 32'h7fffffff);
    load_point(63, 63, 32'h12345678, 32'h80000000, 32'h7fffffff);
    eval_at(32'h0, 32'h0);
    eval_at(32'h8000, 32'h8000);
    eval_at(32'h10000, 32'h10000);
    eval_at(32'h80000000, 32'h7fffffff);
    eval_at(32'hffffffff, 32'h1);
    // zero span on both axes
    set_grid(2, 2, 32'h0, 31'h0, 32'h80000000, 31'h0);
    eval_at(32'h7fffffff, 32'h7fffffff);
    // grid below two on one axis, columns and then rows
    set_grid(1, 64, 32'h0, 31'h10000, 32'h0, 31'h10000);
    eval_at(32'h8000, 32'h8000);
    set_grid(64, 0, 32'h0, 31'h10000, 32'h0, 31'h10000);
    eval_at(32'h8000, 32'h8000);
    // saturated grid size, widest range
    set_grid(127, 100, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
    eval_at(32'h7fffffff, 32'h7fffffff);
    eval_at(32'h80000000, 32'h0);
    eval_at(32'h0, 32'h80000001);
    // upper edge on a full grid
    set_grid(64, 64, 32'hffff0000, 31'h20000, 32'h0, 31'h1);
    eval_at(32'h10000, 32'h1);
    eval_at(32'h0ffff, 32'h0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      set_grid($urandom_range(FILL_LO), $urandom_range(FILL_LO), $urandom,
               31'($urandom), $urandom, 31'($urandom));
      if (phase == 1)
        set_grid(FILL_LO, FILL_LO, 32'h0, 31'h40000, 32'hfffe0000, 31'h40000);
      if (phase == 2)
        set_grid($urandom_range(2, 8), $urandom_range(2, 8), 32'h0, 31'h10000,
                 32'h0, 31'h10000);
      for (int i = 0; i < 150; i++) begin
        gse_in_t it;
        calm = (phase == 3);
        it = rand_item();
        // keep parameters mostly inside the range to sweep cells and fractions
        if ($urandom_range(3) != 0) begin
          it.u_param = ulow_q + 32'($urandom_range(0, 32'(uspan_q) + 16));
          it.v_param = vlow_q + 32'($urandom_range(0, 32'(vspan_q) + 16));
        end
        send_item(it);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int errs;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_COLS;
    cfg_data_i = '0;
    mismatches = 0;
    calm = 1'b0;
    cols_q = 7'd2;
    rows_q = 7'd2;
    ulow_q = '0;
    vlow_q = '0;
    uspan_q = 31'd65536;
    vspan_q = 31'd65536;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_store();
    test_directed();
    test_random();
    drain();
    errs = mismatches;
    if (errs == 0) begin
      $display("bilinear_grid_surface_eval: match");
    end else begin
      $display("bilinear_grid_surface_eval: mismatch");
    end
    $finish;
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    gse_out_t want;
    if (rst_ni && result_strobe_o) begin
      if (surf_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = surf_queue.pop_front();
        if (want.surf_x !== result_o.surf_x || want.surf_y !== result_o.surf_y ||
            want.surf_z !== result_o.surf_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("surface point: expected %h %h %h got %h %h %h",
                     want.surf_x, want.surf_y, want.surf_z,
                     result_o.surf_x, result_o.surf_y, result_o.surf_z);
        end
      end
    end
  end

endmodule
